FILE: src/shmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package shmm_pkg;

  localparam int QW = 16;
  localparam int RW = 32;

  typedef struct packed {
    logic [QW-1:0] query_start;
    logic [QW-1:0] query_end;
    logic [RW-1:0] ref_start;
    logic [RW-1:0] ref_end;
    logic          reverse_strand;
    logic [31:0]   ref_id;
    logic          last_of_reference;
    logic          new_query;
  } hit_t;

  typedef struct packed {
    logic [15:0]   match_id;
    logic [QW-1:0] out_query_start;
    logic [QW-1:0] out_query_end;
    logic [RW-1:0] out_ref_start;
    logic [RW-1:0] out_ref_end;
    logic [31:0]   out_ref_id;
    logic [15:0]   hit_count;
    logic          out_reverse;
    logic [31:0]   score;
    logic          last;
    logic          table_full;
  } match_t;

  typedef struct packed {
    logic [QW-1:0] qs;
    logic [QW-1:0] qe;
    logic [QW-1:0] qp;
    logic [RW-1:0] rs;
    logic [RW-1:0] re;
    logic [RW-1:0] rp;
    logic [15:0]   hits;
    logic          strand;
    logic [15:0]   num;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_FULL, ST_FILT, ST_EMIT, ST_FLUSH, ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: src/seed_hit_match_merger.sv
// Seed hit match merger. A hit passes accept, scan (entries examined in turn),
// a full-table step if nothing matched and the table is full, filter (emit closed and
// compact kept entries), flush (emit open entries on a reference's last hit) and done;
// out_ready stalls can hold emission. in_ready is high only in idle: one hit at a time.
// Each item is held until the next is known; the last one leaves in the done state.
// Synchronous active-low reset empties the table and clears counters; k resets to 20.
`timescale 1ns / 1ps
`default_nettype none
module seed_hit_match_merger #(
  parameter int OPEN_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire shmm_pkg::hit_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output shmm_pkg::match_t      out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);
  import shmm_pkg::*;

  localparam int IW = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
  localparam int CW = $clog2(OPEN_DEPTH + 1);

  entry_t tbl [OPEN_DEPTH];

  state_t        state_r, state_nxt;
  hit_t          hit_r;
  logic [7:0]    k_r;
  logic [QW-1:0] fp_r;
  logic [15:0]   num_r;
  logic [CW-1:0] cnt_r, idx_r, wr_r;
  logic [31:0]   cref_r;
  logic          out_valid_r;
  match_t        out_r;
  match_t        hold_r;
  logic          hold_v_r;
  logic          phase_r;
  entry_t        cur, newent, ext;
  logic          match;
  logic [31:0]   score;
  logic          do_filt;
  logic          in_tbl;
  logic          tbl_full;
  logic          closing;
  logic          can_emit;
  logic          emit_go;
  logic          release_go;
  logic          out_load;
  match_t        emit_item;
  match_t        load_item;

  function automatic match_t mk(entry_t e, logic [31:0] s, logic [31:0] rid);
    match_t m;
    m = '{match_id: e.num, out_query_start: e.qs, out_query_end: e.qe,
          out_ref_start: e.rs, out_ref_end: e.re, out_ref_id: rid, hit_count: e.hits,
          out_reverse: e.strand, score: s, last: 1'b0, table_full: 1'b0};
    return m;
  endfunction

  function automatic logic [31:0] fscore(hit_t h);
    logic signed [RW+1:0] qsp, rsp, mx, mn;
    logic signed [RW+2:0] t;
    qsp = $signed({2'b00, {(RW-QW){1'b0}}, h.query_end}) -
          $signed({2'b00, {(RW-QW){1'b0}}, h.query_start});
    rsp = $signed({2'b00, h.ref_end}) - $signed({2'b00, h.ref_start});
    mx = (qsp > rsp) ? qsp : rsp;
    mn = (qsp > rsp) ? rsp : qsp;
    t = ($signed({mn[RW+1], mn}) <<< 1) - $signed({mx[RW+1], mx});
    if (t[RW+2] || (t == '0)) return 32'd1;
    if (t > $signed({{(RW-29){1'b0}}, 32'hFFFF_FFFF})) return 32'hFFFF_FFFF;
    return t[31:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur = tbl[idx_r[IW-1:0]];

  shmm_score u_score (.clk(clk), .ent(cur), .score(score));

  always_comb begin
    in_tbl   = (idx_r < cnt_r);
    tbl_full = (cnt_r >= CW'(OPEN_DEPTH));
    closing  = (cur.qe < hit_r.query_start);
    can_emit = !hold_v_r || !out_valid_r;
    match = (cur.qp < hit_r.query_start) && (hit_r.query_start <= cur.qe) &&
            (cur.rp <= hit_r.ref_start) && (hit_r.ref_start <= cur.re);
    ext = cur;
    if (hit_r.query_end > cur.qe) ext.qe = hit_r.query_end;
    if (hit_r.ref_end > cur.re) ext.re = hit_r.ref_end;
    ext.qp = hit_r.query_start;
    ext.rp = hit_r.ref_start;
    if (cur.hits != 16'hFFFF) ext.hits = cur.hits + 16'd1;
    newent = '{qs: hit_r.query_start, qe: hit_r.query_end, qp: hit_r.query_start,
               rs: hit_r.ref_start, re: hit_r.ref_end, rp: hit_r.ref_start,
               hits: 16'd1, strand: hit_r.reverse_strand, num: num_r};
    do_filt = ({1'b0, hit_r.query_start} > ({1'b0, fp_r} + {{QW-7{1'b0}}, k_r}));
  end

  // sequencer: IDLE -> SCAN (extend/add) [-> FULL] -> FILT (emit/compact) -> FLUSH -> DONE
  always_comb begin
    state_nxt  = state_r;
    emit_go    = 1'b0;
    release_go = 1'b0;
    emit_item  = mk(cur, score, cref_r);
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (in_tbl) begin
          if (match) state_nxt = ST_FILT;
        end else if (tbl_full) begin
          state_nxt = ST_FULL;
        end else begin
          state_nxt = ST_FILT;
        end
      end
      ST_FULL: begin
        emit_item = '{match_id: num_r, out_query_start: hit_r.query_start,
                      out_query_end: hit_r.query_end, out_ref_start: hit_r.ref_start,
                      out_ref_end: hit_r.ref_end, out_ref_id: cref_r, hit_count: 16'd1,
                      out_reverse: hit_r.reverse_strand,
                      score: fscore(hit_r), last: 1'b0, table_full: 1'b1};
        if (can_emit) begin
          emit_go = 1'b1;
          state_nxt = ST_FILT;
        end
      end
      ST_FILT: begin
        if (!do_filt || !in_tbl) state_nxt = ST_FLUSH;
        else if (closing && phase_r && can_emit) emit_go = 1'b1;
      end
      ST_FLUSH: begin
        if (!hit_r.last_of_reference || !in_tbl) state_nxt = ST_DONE;
        else if (phase_r && can_emit) emit_go = 1'b1;
      end
      ST_DONE: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r) begin
          release_go = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_load  = (emit_go && hold_v_r) || release_go;
    load_item = hold_r;
    load_item.last = release_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 8'd20;
      fp_r <= '0;
      num_r <= '0;
      cnt_r <= '0;
      cref_r <= '0;
      out_valid_r <= 1'b0;
      hold_v_r <= 1'b0;
      phase_r <= 1'b0;
      idx_r <= '0;
      wr_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) k_r <= cfg_data;
      if (out_load) begin
        out_r <= load_item;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_go) begin
        hold_r <= emit_item;
        hold_v_r <= 1'b1;
      end else if (release_go) begin
        hold_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          hit_r <= in_data;
          if (in_data.new_query) num_r <= '0;
          cref_r <= in_data.ref_id;
          idx_r <= '0;
          phase_r <= 1'b0;
        end
        ST_SCAN: begin
          if (in_tbl) begin
            if (match) begin
              tbl[idx_r[IW-1:0]] <= ext;
              idx_r <= '0; wr_r <= '0; phase_r <= 1'b0;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end else begin
            if (!tbl_full) begin
              tbl[idx_r[IW-1:0]] <= newent;
              cnt_r <= cnt_r + CW'(1);
              num_r <= num_r + 16'd1;
            end
            idx_r <= '0; wr_r <= '0; phase_r <= 1'b0;
          end
        end
        ST_FULL: if (emit_go) num_r <= num_r + 16'd1;
        ST_FILT: begin
          if (!do_filt) begin
            idx_r <= '0; phase_r <= 1'b0;
          end else if (!in_tbl) begin
            cnt_r <= wr_r;
            fp_r <= hit_r.query_start;
            idx_r <= '0; phase_r <= 1'b0;
          end else if (closing) begin
            if (!phase_r) begin
              phase_r <= 1'b1;
            end else if (emit_go) begin
              phase_r <= 1'b0;
              idx_r <= idx_r + CW'(1);
            end
          end else begin
            tbl[wr_r[IW-1:0]] <= cur;
            wr_r <= wr_r + CW'(1);
            idx_r <= idx_r + CW'(1);
          end
        end
        ST_FLUSH: begin
          if (!hit_r.last_of_reference || !in_tbl) begin
            if (hit_r.last_of_reference) begin
              cnt_r <= '0;
              fp_r <= '0;
            end
          end else if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (emit_go) begin
            phase_r <= 1'b0;
            idx_r <= idx_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/shmm_score.sv
`timescale 1ns / 1ps
`default_nettype none
module shmm_score (
  input  wire logic            clk,
  input  wire shmm_pkg::entry_t ent,
  output logic [31:0]          score
);
  import shmm_pkg::*;

  logic signed [RW+1:0] qspan, rspan, mx, mn;
  logic signed [RW+2:0] t;
  logic [31:0] t_r, tc;
  logic        pos_r;
  logic [15:0] hits_r;
  logic [47:0] p;

  always_comb begin
    qspan = $signed({2'b00, {(RW-QW){1'b0}}, ent.qe}) -
            $signed({2'b00, {(RW-QW){1'b0}}, ent.qs});
    rspan = $signed({2'b00, ent.re}) - $signed({2'b00, ent.rs});
    mx = (qspan > rspan) ? qspan : rspan;
    mn = (qspan > rspan) ? rspan : qspan;
    t = ($signed({mn[RW+1], mn}) <<< 1) - $signed({mx[RW+1], mx});
    tc = (t > $signed({{(RW-29){1'b0}}, 32'hFFFF_FFFF})) ? 32'hFFFF_FFFF : t[31:0];
  end

  always_ff @(posedge clk) begin
    t_r    <= tc;
    pos_r  <= !t[RW+2] && (t != '0);
    hits_r <= ent.hits;
  end

  assign p = t_r * hits_r;
  assign score = !pos_r ? 32'd1 : (p[47:32] != '0) ? 32'hFFFF_FFFF : p[31:0];
endmodule
`default_nettype wire
